### design/fct_pkg.sv
package fct_pkg;

	typedef enum logic [2:0] {
		OP_REGISTER        = 3'd0,
		OP_REGISTER_FAILED = 3'd1,
		OP_FENCE_DONE      = 3'd2,
		OP_QUERY           = 3'd3,
		OP_CANCEL          = 3'd4,
		OP_FRAME_START     = 3'd5
	} op_t;

	localparam logic [3:0] ERR_NONE      = 4'd0;
	localparam logic [3:0] ERR_NOT_FOUND = 4'd1;
	localparam logic [3:0] ERR_CANCELED  = 4'd2;
	localparam logic [4:0] ERR_FAIL_BASE = 5'd3;
	localparam logic [4:0] ERR_MAX       = 5'd15;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic init_step;
		logic mod_step;
		logic rd_single;
		logic exec_single;
		logic sweep_step;
		logic fin;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic init_last;
		logic mod_last;
		logic sweep_done;
	} sts_t;

endpackage

### design/fence_completion_tracker.sv
// Fence completion tracker: a ticket table for uploads that takes one
// operation per input beat and returns one result beat for it. Register
// stores a fence and byte count under the next ticket, register_failed
// stores an already failed upload, fence_done completes every pending entry
// at or below a fence, query and cancel look up one ticket, and frame_start
// selects a frame slot and erases the entries created in it. Ticket t lives
// at table position t mod ENTRIES in a single-port-write, registered-read
// memory. After reset the table is cleared in a pass over every entry,
// during which no input beat is taken. Items are handled one at a time.
// After an input beat is accepted, register and register_failed read and
// check the entry at the next position; query and cancel first map the
// ticket to its position in a reciprocal-multiply unit and then read and
// check that entry; fence_done and frame_start sweep every entry through
// the memory port; unknown operations go straight to the result. A result
// beat is held until taken, and the next input beat can be accepted in
// the cycle after that.
module fence_completion_tracker #(
	parameter int ENTRIES = 64,
	parameter int SLOTS   = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  operation,
	input  logic [47:0] fence,
	input  logic [31:0] byte_count,
	input  logic [31:0] ticket_id,
	input  logic [3:0]  failure_code,
	input  logic [2:0]  frame_slot,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] issued_ticket,
	output logic [47:0] issued_fence,
	output logic        found,
	output logic        done_res,
	output logic        success,
	output logic [31:0] bytes_done,
	output logic [3:0]  error,
	output logic        cancel_taken,
	output logic        table_full,
	output logic        any_pending
);
	import fct_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// The controller sequences each operation; the datapath holds the table,
	// the ticket counter, the pending-entry count and the result registers.
	fct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.operation(operation),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd),
		.in_ready (in_ready),
		.out_valid(out_valid)
	);

	fct_dp #(.ENTRIES(ENTRIES), .SLOTS(SLOTS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.operation    (operation),
		.fence        (fence),
		.byte_count   (byte_count),
		.ticket_id    (ticket_id),
		.failure_code (failure_code),
		.frame_slot   (frame_slot),
		.issued_ticket(issued_ticket),
		.issued_fence (issued_fence),
		.found        (found),
		.done_res     (done_res),
		.success      (success),
		.bytes_done   (bytes_done),
		.error        (error),
		.cancel_taken (cancel_taken),
		.table_full   (table_full),
		.any_pending  (any_pending)
	);

endmodule

### design/fct_ram.sv
module fct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### design/fct_ctrl.sv
module fct_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [2:0]    operation,
	input  logic          out_ready,
	input  fct_pkg::sts_t sts,
	output fct_pkg::cmd_t cmd,
	output logic          in_ready,
	output logic          out_valid
);
	import fct_pkg::*;

	typedef enum logic [2:0] {
		ST_INIT, ST_IDLE, ST_MOD, ST_RD, ST_CHK, ST_SWEEP, ST_FIN, ST_OUT
	} state_t;

	state_t state_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	always_comb begin
		cmd             = '0;
		cmd.load        = (state_q == ST_IDLE) && in_valid;
		cmd.init_step   = (state_q == ST_INIT);
		cmd.mod_step    = (state_q == ST_MOD);
		cmd.rd_single   = (state_q == ST_RD);
		cmd.exec_single = (state_q == ST_CHK);
		cmd.sweep_step  = (state_q == ST_SWEEP);
		cmd.fin         = (state_q == ST_FIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					if (sts.init_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) begin
						unique case (op_t'(operation))
							OP_REGISTER, OP_REGISTER_FAILED: state_q <= ST_RD;
							OP_QUERY, OP_CANCEL:             state_q <= ST_MOD;
							OP_FENCE_DONE, OP_FRAME_START:   state_q <= ST_SWEEP;
							default:                         state_q <= ST_FIN;
						endcase
					end
				end
				ST_MOD: begin
					if (sts.mod_last) state_q <= ST_RD;
				end
				ST_RD:  state_q <= ST_CHK;
				ST_CHK: state_q <= ST_FIN;
				ST_SWEEP: begin
					if (sts.sweep_done) state_q <= ST_FIN;
				end
				ST_FIN: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_ready) state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### design/fct_dp.sv
module fct_dp #(
	parameter int ENTRIES = 64,
	parameter int SLOTS   = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  fct_pkg::cmd_t cmd,
	output fct_pkg::sts_t sts,
	input  logic [2:0]    operation,
	input  logic [47:0]   fence,
	input  logic [31:0]   byte_count,
	input  logic [31:0]   ticket_id,
	input  logic [3:0]    failure_code,
	input  logic [2:0]    frame_slot,
	output logic [31:0]   issued_ticket,
	output logic [47:0]   issued_fence,
	output logic          found,
	output logic          done_res,
	output logic          success,
	output logic [31:0]   bytes_done,
	output logic [3:0]    error,
	output logic          cancel_taken,
	output logic          table_full,
	output logic          any_pending
);
	import fct_pkg::*;

	localparam int IW = $clog2(ENTRIES);
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int PW = $clog2(ENTRIES + 1);

	// Low 32 bits of the 33-bit reciprocal of ENTRIES; bit 32 is always set.
	localparam logic [31:0] RECIP_LO =
		32'(((64'd1 << (32 + IW)) / 64'(ENTRIES)) + 64'd1);

	typedef struct packed {
		logic          vld;
		logic [31:0]   tkt;
		logic [47:0]   fen;
		logic [31:0]   byt;
		logic          dn;
		logic          ok;
		logic [3:0]    err;
		logic [SW-1:0] slt;
	} entry_t;

	function automatic logic [SW-1:0] slot_mod(input logic [2:0] s);
		logic [4:0] v;
		v = {2'b00, s};
		for (int k = 0; k < 8; k++) begin
			if (v >= 5'(SLOTS)) v = v - 5'(SLOTS);
		end
		return SW'(v);
	endfunction

	// Latched item.
	op_t         op_q;
	logic [47:0] fence_q;
	logic [31:0] bytes_q;
	logic [31:0] tid_q;
	logic [3:0]  code_q;

	// Tracker state.
	logic [31:0]   next_ticket_q;
	logic [IW-1:0] next_pos_q;
	logic [47:0]   cfv_q;
	logic [SW-1:0] active_slot_q;
	logic [PW-1:0] pend_q;

	// Position unit, sweep counter and write stage.
	logic [1:0]    step_q;
	logic [63:0]   prod_q;
	logic [31:0]   quo_q;
	logic [IW-1:0] rem_q;
	logic [IW:0]   cnt_q;
	logic          wr_s1;
	logic [IW-1:0] waddr_s1;

	logic          we;
	logic [IW-1:0] waddr, raddr;
	entry_t        wdata, rdata;
	logic          pend_dec, pend_inc;

	fct_ram #(.WIDTH($bits(entry_t)), .DEPTH(ENTRIES)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign sts.init_last  = (cnt_q == (IW+1)'(ENTRIES - 1));
	assign sts.mod_last   = (step_q == 2'd0);
	assign sts.sweep_done = (cnt_q == (IW+1)'(ENTRIES)) && !wr_s1;

	logic [64:0]   prod_sum;
	logic [31:0]   quo_next;
	logic [31:0]   diff;
	logic [IW-1:0] pos;
	logic          hit;
	logic [4:0]    fail_err;
	entry_t        upd;

	always_comb begin
		prod_sum = {1'b0, tid_q, 32'd0} + {1'b0, prod_q};
		quo_next = 32'(prod_sum >> (32 + IW));
		diff     = tid_q - quo_q * 32'(ENTRIES);

		pos = (op_q == OP_REGISTER || op_q == OP_REGISTER_FAILED) ? next_pos_q : rem_q;
		raddr = cmd.rd_single ? pos : cnt_q[IW-1:0];
		hit = rdata.vld && (rdata.tkt == tid_q);
		fail_err = {1'b0, code_q} + ERR_FAIL_BASE;
		if (fail_err > ERR_MAX) fail_err = ERR_MAX;

		we       = 1'b0;
		waddr    = pos;
		wdata    = rdata;
		upd      = rdata;
		pend_dec = 1'b0;
		pend_inc = 1'b0;

		if (cmd.init_step) begin
			we    = 1'b1;
			waddr = cnt_q[IW-1:0];
			wdata = '0;
		end else if (cmd.exec_single) begin
			if (op_q == OP_REGISTER || op_q == OP_REGISTER_FAILED) begin
				upd.vld = 1'b1;
				upd.tkt = next_ticket_q;
				upd.slt = active_slot_q;
				upd.ok  = 1'b0;
				if (op_q == OP_REGISTER) begin
					upd.fen = fence_q;
					upd.byt = bytes_q;
					upd.dn  = 1'b0;
					upd.err = ERR_NONE;
				end else begin
					upd.fen = cfv_q;
					upd.byt = '0;
					upd.dn  = 1'b1;
					upd.err = fail_err[3:0];
				end
				we       = !rdata.vld;
				pend_inc = !rdata.vld && (op_q == OP_REGISTER);
			end else if (op_q == OP_CANCEL && hit && !rdata.dn) begin
				upd.dn   = 1'b1;
				upd.ok   = 1'b0;
				upd.err  = ERR_CANCELED;
				we       = 1'b1;
				pend_dec = 1'b1;
			end
			wdata = upd;
		end else if (wr_s1) begin
			waddr = waddr_s1;
			if (op_q == OP_FENCE_DONE) begin
				if (rdata.vld && !rdata.dn && rdata.fen <= fence_q) begin
					upd.dn   = 1'b1;
					upd.ok   = 1'b1;
					upd.err  = ERR_NONE;
					we       = 1'b1;
					pend_dec = 1'b1;
				end
			end else if (rdata.vld && rdata.slt == active_slot_q) begin
				upd.vld  = 1'b0;
				we       = 1'b1;
				pend_dec = !rdata.dn;
			end
			wdata = upd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_ticket_q <= '0;
			next_pos_q    <= '0;
			cfv_q         <= '0;
			active_slot_q <= '0;
			pend_q        <= '0;
			cnt_q         <= '0;
			wr_s1         <= 1'b0;
			step_q        <= '0;
			prod_q        <= '0;
			quo_q         <= '0;
			rem_q         <= '0;
		end else begin
			if (pend_inc) pend_q <= pend_q + PW'(1);
			else if (pend_dec) pend_q <= pend_q - PW'(1);

			if (cmd.init_step) cnt_q <= cnt_q + (IW+1)'(1);

			if (cmd.load) begin
				rem_q  <= '0;
				step_q <= 2'd2;
				cnt_q  <= '0;
				wr_s1  <= 1'b0;
				if (op_t'(operation) == OP_FRAME_START) active_slot_q <= slot_mod(frame_slot);
			end

			// Ticket to position: multiply by the reciprocal, take the
			// quotient, then subtract quotient times ENTRIES.
			if (cmd.mod_step) begin
				step_q <= step_q - 2'd1;
				if (step_q == 2'd2) prod_q <= {32'd0, tid_q} * {32'd0, RECIP_LO};
				if (step_q == 2'd1) quo_q <= quo_next;
				if (step_q == 2'd0) rem_q <= diff[IW-1:0];
			end

			if (cmd.sweep_step) begin
				if (cnt_q != (IW+1)'(ENTRIES)) begin
					cnt_q <= cnt_q + (IW+1)'(1);
					wr_s1 <= 1'b1;
				end else begin
					wr_s1 <= 1'b0;
				end
			end

			if (cmd.exec_single && !rdata.vld &&
			    (op_q == OP_REGISTER || op_q == OP_REGISTER_FAILED)) begin
				next_ticket_q <= next_ticket_q + 32'd1;
				if (next_ticket_q == '1 || next_pos_q == IW'(ENTRIES - 1)) next_pos_q <= '0;
				else next_pos_q <= next_pos_q + IW'(1);
			end

			if (cmd.fin && op_q == OP_FENCE_DONE && fence_q > cfv_q) cfv_q <= fence_q;
		end
	end

	// Item and result registers carry payload only.
	always_ff @(posedge clk) begin
		waddr_s1 <= cnt_q[IW-1:0];
		if (cmd.load) begin
			op_q          <= op_t'(operation);
			fence_q       <= fence;
			bytes_q       <= byte_count;
			tid_q         <= ticket_id;
			code_q        <= failure_code;
			issued_ticket <= '0;
			issued_fence  <= '0;
			found         <= 1'b0;
			done_res      <= 1'b0;
			success       <= 1'b0;
			bytes_done    <= '0;
			error         <= ERR_NONE;
			cancel_taken  <= 1'b0;
			table_full    <= 1'b0;
		end
		if (cmd.exec_single) begin
			if (op_q == OP_REGISTER || op_q == OP_REGISTER_FAILED) begin
				if (rdata.vld) begin
					table_full <= 1'b1;
				end else begin
					issued_ticket <= next_ticket_q;
					issued_fence  <= upd.fen;
				end
			end else if (hit) begin
				found        <= 1'b1;
				cancel_taken <= (op_q == OP_CANCEL) && !rdata.dn;
				if (upd.dn) begin
					done_res   <= 1'b1;
					success    <= upd.ok;
					bytes_done <= upd.ok ? upd.byt : '0;
					error      <= upd.err;
				end
			end else begin
				error <= ERR_NOT_FOUND;
			end
		end
		if (cmd.fin) any_pending <= (pend_q != '0);
	end

endmodule

### sim/fct_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the fence completion tracker, keeps its own
// model of the ticket table, and compares every result beat in order.
module fct_checker #(
	parameter int ENTRIES = 64,
	parameter int SLOTS   = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [2:0]  operation,
	input  logic [47:0] fence,
	input  logic [31:0] byte_count,
	input  logic [31:0] ticket_id,
	input  logic [3:0]  failure_code,
	input  logic [2:0]  frame_slot,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] issued_ticket,
	input  logic [47:0] issued_fence,
	input  logic        found,
	input  logic        done_res,
	input  logic        success,
	input  logic [31:0] bytes_done,
	input  logic [3:0]  error,
	input  logic        cancel_taken,
	input  logic        table_full,
	input  logic        any_pending,
	output int          fail_count,
	output int          pending_results
);
	import fct_pkg::*;

	typedef struct packed {
		logic [31:0] ticket;
		logic [47:0] fnc;
		logic        fnd;
		logic        dn;
		logic        ok;
		logic [31:0] bytes;
		logic [3:0]  err;
		logic        canceled;
		logic        full;
		logic        pend;
	} outcome_t;

	typedef struct packed {
		logic [31:0] ticket;
		logic [47:0] fnc;
		logic [31:0] bytes;
		logic        dn;
		logic        ok;
		logic [3:0]  err;
		logic [2:0]  slot;
	} entry_t;

	outcome_t    expected_q[$];
	logic        live[ENTRIES];
	entry_t      tbl[ENTRIES];
	logic [31:0] ticket_ctr;
	logic [47:0] done_fence;
	logic [2:0]  cur_slot;

	function automatic outcome_t apply_op(logic [2:0] op, logic [47:0] f, logic [31:0] b,
			logic [31:0] tid, logic [3:0] code, logic [2:0] fs);
		outcome_t o;
		int p;
		int e;
		o = '0;
		if (op == OP_REGISTER || op == OP_REGISTER_FAILED) begin
			p = ticket_ctr % ENTRIES;
			if (live[p]) begin
				o.full = 1'b1;
			end else begin
				e = code + 3;
				if (e > 15)
					e = 15;
				live[p] = 1'b1;
				tbl[p].ticket = ticket_ctr;
				tbl[p].fnc = (op == OP_REGISTER) ? f : done_fence;
				tbl[p].bytes = (op == OP_REGISTER) ? b : 32'd0;
				tbl[p].dn = (op != OP_REGISTER);
				tbl[p].ok = 1'b0;
				tbl[p].err = (op == OP_REGISTER) ? ERR_NONE : 4'(e);
				tbl[p].slot = cur_slot;
				o.ticket = ticket_ctr;
				o.fnc = tbl[p].fnc;
				ticket_ctr = ticket_ctr + 1;
			end
		end else if (op == OP_FENCE_DONE) begin
			if (f > done_fence)
				done_fence = f;
			for (int i = 0; i < ENTRIES; i++)
				if (live[i] && !tbl[i].dn && tbl[i].fnc <= f) begin
					tbl[i].dn = 1'b1;
					tbl[i].ok = 1'b1;
					tbl[i].err = ERR_NONE;
				end
		end else if (op == OP_QUERY || op == OP_CANCEL) begin
			p = tid % ENTRIES;
			if (live[p] && tbl[p].ticket == tid) begin
				if (op == OP_CANCEL && !tbl[p].dn) begin
					tbl[p].dn = 1'b1;
					tbl[p].ok = 1'b0;
					tbl[p].err = ERR_CANCELED;
					o.canceled = 1'b1;
				end
				o.fnd = 1'b1;
				if (tbl[p].dn) begin
					o.dn = 1'b1;
					o.ok = tbl[p].ok;
					o.bytes = tbl[p].ok ? tbl[p].bytes : 32'd0;
					o.err = tbl[p].err;
				end
			end else begin
				o.err = ERR_NOT_FOUND;
			end
		end else if (op == OP_FRAME_START) begin
			cur_slot = 3'(fs % SLOTS);
			for (int i = 0; i < ENTRIES; i++)
				if (live[i] && tbl[i].slot == cur_slot)
					live[i] = 1'b0;
		end
		for (int i = 0; i < ENTRIES; i++)
			if (live[i] && !tbl[i].dn)
				o.pend = 1'b1;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t seen;
		outcome_t want;
		if (!arst_n) begin
			fail_count <= 0;
			ticket_ctr = '0;
			done_fence = '0;
			cur_slot = '0;
			for (int i = 0; i < ENTRIES; i++)
				live[i] = 1'b0;
			expected_q.delete();
			pending_results = 0;
		end else begin
			if (out_valid && out_ready) begin
				seen = {issued_ticket, issued_fence, found, done_res, success,
					bytes_done, error, cancel_taken, table_full, any_pending};
				if (expected_q.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: result beat with nothing expected: %h", $realtime, seen);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_q.pop_front();
					if (seen !== want) begin
						if (fail_count < 10)
							$display("%0t: mismatch expected %p actual %p", $realtime, want, seen);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && in_ready)
				expected_q.insert(expected_q.size(), apply_op(operation, fence, byte_count,
					ticket_id, failure_code, frame_slot));
			pending_results = expected_q.size();
		end
	end

endmodule

### sim/fence_completion_tracker_tb.sv
`timescale 1ns / 100ps

// Stimulus for the fence completion tracker. A directed opening covers the
// special cases, then random bursts of mostly registering, completing and
// looking up recent tickets keep the table busy. The checker beside the
// block does all prediction and comparison.
module fence_completion_tracker_tb;
	import fct_pkg::*;

	localparam int ENTRIES = 64;
	localparam int WATCHDOG = 20000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  operation;
	logic [47:0] fence;
	logic [31:0] byte_count;
	logic [31:0] ticket_id;
	logic [3:0]  failure_code;
	logic [2:0]  frame_slot;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] issued_ticket;
	logic [47:0] issued_fence;
	logic        found;
	logic        done_res;
	logic        success;
	logic [31:0] bytes_done;
	logic [3:0]  error;
	logic        cancel_taken;
	logic        table_full;
	logic        any_pending;
	int          fail_count;
	int          pending_results;
	int          idle_cycles = 0;
	logic [31:0] tickets_issued = '0;
	logic [47:0] fence_hi;

	fence_completion_tracker dut (.*);

	fct_checker #(.ENTRIES(ENTRIES), .SLOTS(8)) checker_i (.*);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Any accepted beat on either side resets the stall counter.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Track issued tickets so lookups can hit live ones.
	always @(posedge clk)
		if (out_valid && out_ready && !table_full &&
				(issued_ticket != 0 || issued_fence != 0 || tickets_issued == 0))
			tickets_issued <= tickets_issued + 1;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	// Receiver side: ready drops for random stretches, with calm phases.
	initial begin
		int g;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			g = gap_len();
			if (g > 0) begin
				out_ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// Present one beat and hold it until accepted. Valid stays high from
	// one beat to the next when there is no gap.
	task automatic send_op(logic [2:0] op, logic [47:0] f, logic [31:0] b,
			logic [31:0] tid, logic [3:0] code, logic [2:0] fs);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		fence <= f;
		byte_count <= b;
		ticket_id <= tid;
		failure_code <= code;
		frame_slot <= fs;
		do
			@(posedge clk);
		while (!(in_valid && in_ready));
	endtask

	function automatic logic [47:0] rnd48();
		return {16'($urandom), $urandom};
	endfunction

	// A ticket near the recent ones, or occasionally anything at all.
	function automatic logic [31:0] pick_ticket();
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		return tickets_issued - $urandom_range(1, 70);
	endfunction

	initial begin
		int r;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		operation <= '0;
		fence <= '0;
		byte_count <= '0;
		ticket_id <= '0;
		failure_code <= '0;
		frame_slot <= '0;
		fence_hi = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening: extremes of fields, pending and completed
		// lookups, cancel of pending and completed, missing tickets,
		// saturating failure codes, unknown operations and slot changes.
		send_op(OP_QUERY, '0, '0, 32'd0, '0, '0);
		send_op(OP_REGISTER, '1, '1, '0, '0, '0);
		send_op(OP_REGISTER, 48'd5, 32'd100, '0, '0, '0);
		send_op(OP_REGISTER_FAILED, '0, '0, '0, 4'd12, '0);
		send_op(OP_REGISTER_FAILED, '0, '0, '0, 4'd15, '0);
		send_op(OP_QUERY, '0, '0, 32'd1, '0, '0);
		send_op(OP_FENCE_DONE, 48'd5, '0, '0, '0, '0);
		send_op(OP_QUERY, '0, '0, 32'd1, '0, '0);
		send_op(OP_CANCEL, '0, '0, 32'd1, '0, '0);
		send_op(OP_CANCEL, '0, '0, 32'd0, '0, '0);
		send_op(OP_QUERY, '0, '0, 32'd0, '0, '0);
		send_op(OP_QUERY, '0, '0, 32'd3, '0, '0);
		send_op(OP_CANCEL, '0, '0, '1, '0, '0);
		send_op(3'd6, '1, '1, '1, '1, '1);
		send_op(3'd7, '0, '0, '0, '0, '0);
		send_op(OP_FRAME_START, '0, '0, '0, '0, 3'd7);
		send_op(OP_REGISTER, 48'd9, 32'd1, '0, '0, '0);
		send_op(OP_FRAME_START, '0, '0, '0, '0, 3'd0);
		send_op(OP_QUERY, '0, '0, 32'd2, '0, '0);
		send_op(OP_FENCE_DONE, '1, '0, '0, '0, '0);
		send_op(OP_REGISTER_FAILED, '0, '0, '0, 4'd0, '0);
		send_op(OP_FENCE_DONE, 48'd3, '0, '0, '0, '0);
		send_op(OP_FRAME_START, '0, '0, '0, '0, 3'd7);
		send_op(OP_FRAME_START, '0, '0, '0, '0, 3'd0);

		// Random traffic: fences climb slowly so fence_done completes some
		// entries and leaves others pending; table fills now and then.
		fence_hi = 48'd10;
		repeat (850) begin
			r = $urandom_range(0, 99);
			if (r < 35)
				send_op(OP_REGISTER, ($urandom_range(0, 19) == 0) ? rnd48()
					: fence_hi + $urandom_range(0, 40), $urandom, $urandom,
					4'($urandom), 3'($urandom));
			else if (r < 42)
				send_op(OP_REGISTER_FAILED, rnd48(), $urandom, $urandom,
					4'($urandom), 3'($urandom));
			else if (r < 50) begin
				fence_hi = fence_hi + $urandom_range(0, 30);
				send_op(OP_FENCE_DONE, ($urandom_range(0, 19) == 0) ? rnd48()
					: fence_hi, $urandom, $urandom, 4'($urandom), 3'($urandom));
			end else if (r < 72)
				send_op(OP_QUERY, rnd48(), $urandom, pick_ticket(), 4'($urandom),
					3'($urandom));
			else if (r < 90)
				send_op(OP_CANCEL, rnd48(), $urandom, pick_ticket(), 4'($urandom),
					3'($urandom));
			else if (r < 97)
				send_op(OP_FRAME_START, rnd48(), $urandom, $urandom, 4'($urandom),
					3'($urandom));
			else
				send_op(3'($urandom_range(6, 7)), rnd48(), $urandom, $urandom,
					4'($urandom), 3'($urandom));
		end
		in_valid <= 1'b0;

		// Let the checker take in the last beat before draining.
		repeat (2) @(posedge clk);
		wait (pending_results == 0);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### filelist.f
design/fct_pkg.sv
design/fct_ram.sv
design/fct_ctrl.sv
design/fct_dp.sv
design/fence_completion_tracker.sv
sim/fct_checker.sv
sim/fence_completion_tracker_tb.sv
